// ===== sv/rhfda_pkg.sv =====
// Shared types, codes and constants of the rx hub flit delivery arbiter.
// Used by rhfda_mod_unit and rx_hub_flit_delivery_arbiter; depends on nothing.
package rhfda_pkg;

   localparam int DEF_NUM_SOURCES = 8;
   localparam int DEF_FIFO_DEPTH  = 8;
   localparam int NUM_ROUTERS     = 64;
   localparam int ROUTER_CMP_W    = 9;   // wide enough for any router count up to 256

   localparam int LFSR_W          = 16;
   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
   localparam logic [LFSR_W-1:0] SEED_RESET = 16'd1;
   localparam logic [3:0]        LIMIT_RESET = 4'd4;
   localparam int LIMIT_CMP_W     = 6;   // holds any FIFO depth up to 32

   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int REQ_TDATA_W     = 56;
   localparam int RSP_TDATA_W     = 48;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] KIND_HEAD = 2'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BUFFER_LIMIT  = 2'd0,
      CSR_SOURCE_ENABLE = 2'd1,
      CSR_RANDOM_SEED   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_DISABLED = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // input beat, lowest field in the lowest bits
   typedef struct packed {
      logic [31:0] flit_payload;
      logic [1:0]  flit_kind;
      logic [5:0]  flit_dest;
      logic [5:0]  request_router;
      logic [2:0]  source_hub;
   } req_item_type;

   localparam int REQ_ITEM_W = $bits(req_item_type);

   // result beat, lowest field in the lowest bits
   typedef struct packed {
      logic [31:0] out_payload;
      logic [1:0]  out_kind;
      logic [5:0]  out_dest;
      logic [2:0]  out_source;
      logic        out_valid;
      status_type  status;
   } rsp_item_type;

   localparam int RSP_ITEM_W = $bits(rsp_item_type);

   // one stored flit
   typedef struct packed {
      logic [31:0] payload;
      logic [1:0]  kind;
      logic [5:0]  dest;
   } flit_word_type;

   localparam int FLIT_W = $bits(flit_word_type);

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   // Galois step: shift right, fold the taps in when a one drops out
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] value);
      logic [LFSR_W-1:0] shifted;
      shifted = value >> 1;
      return value[0] ? (shifted ^ LFSR_TAPS) : shifted;
   endfunction

endpackage

// ===== sv/rx_hub_flit_delivery_arbiter.sv =====
// Top level of the rx hub flit delivery arbiter: per-source flit FIFOs kept in
// one RAM, head-flit cache, LFSR pick. Depends on rhfda_pkg, rhfda_ram and
// rhfda_mod_unit.
//
// Usage
//   req_* carries one command beat: a push of a flit into the FIFO of
//   source_hub, or a pop of a flit for request_router (req_tuser selects).
//   Every command gives exactly one beat on rsp_*: a status code and, for a
//   successful pop, the delivered flit with its source hub.
//   csr_* writes buffer_limit, source_enable_mask and random_seed; write only
//   while the block is idle. A seed write reloads the LFSR at once.
// Sequencing
//   A command is taken into a holding register, then worked on alone.
//   Push: accept, then commit to the flit RAM.
//   Pop served by a body or tail flit: accept, head scan, RAM read, deliver,
//   head refresh read; the refresh read is skipped when the FIFO is left empty.
//   Pop choosing among head flits: as above, with a pick step after the head
//   scan in which the 16-step remainder unit takes the LFSR modulo the number
//   of waiting heads.
//   Failed pops and refused pushes end after the accept and the check step.
// Reset and stalls
//   Reset empties every FIFO, restores the register defaults and loads the
//   LFSR with 1; flit RAM contents are left as they are.
//   A result waits in the output register while rsp_tready is low; the next
//   command is still accepted and held until the output register frees up.
module rx_hub_flit_delivery_arbiter #(
   parameter int NUM_SOURCES = rhfda_pkg::DEF_NUM_SOURCES,
   parameter int FIFO_DEPTH  = rhfda_pkg::DEF_FIFO_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_we,
   input  logic [rhfda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rhfda_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // command channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: source_hub[3], request_router[6], flit_dest[6],
   // flit_kind[2], flit_payload[32], zero padding
   input  logic [rhfda_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: func (0 push, 1 pop)
   input  logic [0:0]                        req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: status[2], out_valid[1], out_source[3], out_dest[6],
   // out_kind[2], out_payload[32], zero padding
   output logic [rhfda_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int SW        = $clog2(NUM_SOURCES);
   localparam int PW        = $clog2(FIFO_DEPTH);
   localparam int FW        = $clog2(FIFO_DEPTH + 1);
   localparam int CW        = $clog2(NUM_SOURCES + 1);
   localparam int AW        = SW + PW;
   localparam int RAM_DEPTH = NUM_SOURCES << PW;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_EXEC    = 6'b000010,
      S_MOD     = 6'b000100,
      S_LOAD    = 6'b001000,
      S_READ    = 6'b010000,
      S_REFRESH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [3:0]                   limit_ff, limit_in;
   logic [7:0]                   mask_ff, mask_in;
   logic [rhfda_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;

   // held command
   rhfda_pkg::req_item_type item_ff, item_in;
   logic                    func_ff, func_in;
   logic [SW-1:0]           sel_ff, sel_in;

   // per-source FIFO bookkeeping and head cache
   logic [PW-1:0] rp_ff [NUM_SOURCES];
   logic [PW-1:0] rp_in [NUM_SOURCES];
   logic [PW-1:0] wp_ff [NUM_SOURCES];
   logic [PW-1:0] wp_in [NUM_SOURCES];
   logic [FW-1:0] fill_ff [NUM_SOURCES];
   logic [FW-1:0] fill_in [NUM_SOURCES];
   logic [5:0]    hdest_ff [NUM_SOURCES];
   logic [5:0]    hdest_in [NUM_SOURCES];
   logic [1:0]    hkind_ff [NUM_SOURCES];
   logic [1:0]    hkind_in [NUM_SOURCES];

   // output register
   rhfda_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    result_we;
   logic                    rsp_free;

   // flit RAM
   logic                     ram_we, ram_re;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   rhfda_pkg::flit_word_type ram_wdata, ram_rdata;

   // remainder unit
   logic                      mod_start;
   rhfda_pkg::mod_status_type mod_status;
   logic [CW-1:0]             mod_rem;
   logic [CW-1:0]             nheads;

   // head scan
   logic [NUM_SOURCES-1:0] body_m, head_m;
   logic                   any_body;
   logic [SW-1:0]          body_pick, head_pick;
   logic                   router_bad;
   logic [rhfda_pkg::ROUTER_CMP_W-1:0] ROUTER_CMP_LHS;
   logic                   hub_ok, fifo_full;
   logic [rhfda_pkg::LIMIT_CMP_W-1:0] limit_eff;
   logic [PW-1:0]          rp_next, wp_next;
   logic                   overfill;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // scan the cached heads of all live sources against the requested router
   always_comb begin
      logic                   live;
      logic [NUM_SOURCES-1:0] below;
      body_m    = '0;
      head_m    = '0;
      body_pick = '0;
      head_pick = '0;
      overfill  = 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
         live = (s < 8) && mask_ff[3'(s)] && (fill_ff[s] != '0)
                && (hdest_ff[s] == item_ff.request_router);
         body_m[s] = live && (hkind_ff[s] != rhfda_pkg::KIND_HEAD);
         head_m[s] = live && (hkind_ff[s] == rhfda_pkg::KIND_HEAD);
         if (fill_ff[s] > FW'(FIFO_DEPTH)) begin
            overfill = 1'b1;
         end
      end
      // lowest-numbered body or tail flit wins
      for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
         if (body_m[s]) begin
            body_pick = SW'(s);
         end
      end
      // head flit whose rank among waiting heads equals the remainder
      for (int s = 0; s < NUM_SOURCES; s++) begin
         below = head_m & ((NUM_SOURCES'(1) << s) - NUM_SOURCES'(1));
         if (head_m[s] && (CW'($countones(below)) == mod_rem)) begin
            head_pick = SW'(s);
         end
      end
   end

   assign any_body   = (body_m != '0);
   assign nheads     = CW'($countones(head_m));
   assign router_bad = ROUTER_CMP_LHS >= rhfda_pkg::ROUTER_CMP_W'(rhfda_pkg::NUM_ROUTERS);

   assign ROUTER_CMP_LHS = rhfda_pkg::ROUTER_CMP_W'(item_ff.request_router);

   // push acceptance: source present and enabled, fill below clamped limit
   assign limit_eff = (limit_ff == 4'd0) ? rhfda_pkg::LIMIT_CMP_W'(1) :
                      (rhfda_pkg::LIMIT_CMP_W'(limit_ff) > rhfda_pkg::LIMIT_CMP_W'(FIFO_DEPTH))
                         ? rhfda_pkg::LIMIT_CMP_W'(FIFO_DEPTH)
                         : rhfda_pkg::LIMIT_CMP_W'(limit_ff);
   assign hub_ok    = (int'(item_ff.source_hub) < NUM_SOURCES)
                      && mask_ff[item_ff.source_hub];
   assign fifo_full = rhfda_pkg::LIMIT_CMP_W'(fill_ff[sel_ff]) >= limit_eff;

   assign rp_next = (rp_ff[sel_ff] == PW'(FIFO_DEPTH - 1)) ? '0 : rp_ff[sel_ff] + PW'(1);
   assign wp_next = (wp_ff[sel_ff] == PW'(FIFO_DEPTH - 1)) ? '0 : wp_ff[sel_ff] + PW'(1);

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      mask_in      = mask_ff;
      lfsr_in      = lfsr_ff;
      item_in      = item_ff;
      func_in      = func_ff;
      sel_in       = sel_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      hdest_in     = hdest_ff;
      hkind_in     = hkind_ff;
      rsp_in       = rsp_ff;
      result_we    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = {sel_ff, wp_ff[sel_ff]};
      ram_wdata    = '{payload: item_ff.flit_payload, kind: item_ff.flit_kind,
                       dest: item_ff.flit_dest};
      ram_re       = 1'b0;
      ram_raddr    = {sel_ff, rp_ff[sel_ff]};
      mod_start    = 1'b0;

      // register writes; unknown indexes drop
      if (csr_we) begin
         unique case (csr_index)
            rhfda_pkg::CSR_BUFFER_LIMIT:  limit_in = csr_wdata[3:0];
            rhfda_pkg::CSR_SOURCE_ENABLE: mask_in  = csr_wdata[7:0];
            rhfda_pkg::CSR_RANDOM_SEED: begin
               lfsr_in = (csr_wdata == '0) ? rhfda_pkg::SEED_RESET : csr_wdata;
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in  = rhfda_pkg::req_item_type'(req_tdata[rhfda_pkg::REQ_ITEM_W-1:0]);
               func_in  = req_tuser[0];
               sel_in   = SW'(item_in.source_hub);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (func_ff == rhfda_pkg::FUNC_PUSH) begin
               // hold until the output register is free, then commit
               if (rsp_free) begin
                  result_we = 1'b1;
                  rsp_in    = '0;
                  if (!hub_ok) begin
                     rsp_in.status = rhfda_pkg::ST_DISABLED;
                  end else if (fifo_full) begin
                     rsp_in.status = rhfda_pkg::ST_FULL;
                  end else begin
                     rsp_in.status   = rhfda_pkg::ST_DONE;
                     ram_we          = 1'b1;
                     wp_in[sel_ff]   = wp_next;
                     fill_in[sel_ff] = fill_ff[sel_ff] + FW'(1);
                     // empty FIFO: the new flit is the head
                     if (fill_ff[sel_ff] == '0) begin
                        hdest_in[sel_ff] = item_ff.flit_dest;
                        hkind_in[sel_ff] = item_ff.flit_kind;
                     end
                  end
                  state_in = S_IDLE;
               end
            end else if (router_bad || (!any_body && nheads == '0)) begin
               if (rsp_free) begin
                  result_we     = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = rhfda_pkg::ST_EMPTY;
                  state_in      = S_IDLE;
               end
            end else if (any_body) begin
               sel_in   = body_pick;
               state_in = S_LOAD;
            end else begin
               // advance before every pick among heads, then reduce
               lfsr_in   = rhfda_pkg::lfsr_step(lfsr_ff);
               mod_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_status.done) begin
               sel_in   = head_pick;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ram_re   = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (rsp_free) begin
               result_we          = 1'b1;
               rsp_in.status      = rhfda_pkg::ST_DONE;
               rsp_in.out_valid   = 1'b1;
               rsp_in.out_source  = 3'(sel_ff);
               rsp_in.out_dest    = ram_rdata.dest;
               rsp_in.out_kind    = ram_rdata.kind;
               rsp_in.out_payload = ram_rdata.payload;
               rp_in[sel_ff]      = rp_next;
               fill_in[sel_ff]    = fill_ff[sel_ff] - FW'(1);
               // fetch the next head of this FIFO if one is left
               if (fill_ff[sel_ff] > FW'(1)) begin
                  ram_re    = 1'b1;
                  ram_raddr = {sel_ff, rp_next};
                  state_in  = S_REFRESH;
               end else begin
                  state_in  = S_IDLE;
               end
            end
         end
         S_REFRESH: begin
            hdest_in[sel_ff] = ram_rdata.dest;
            hkind_in[sel_ff] = ram_rdata.kind;
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (result_we) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= rhfda_pkg::LIMIT_RESET;
         mask_ff      <= '0;
         lfsr_ff      <= rhfda_pkg::SEED_RESET;
         rp_ff        <= '{default: '0};
         wp_ff        <= '{default: '0};
         fill_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         mask_ff      <= mask_in;
         lfsr_ff      <= lfsr_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      func_ff  <= func_in;
      sel_ff   <= sel_in;
      hdest_ff <= hdest_in;
      hkind_ff <= hkind_in;
      rsp_ff   <= rsp_in;
   end

   rhfda_ram #(
      .WIDTH (rhfda_pkg::FLIT_W),
      .DEPTH (RAM_DEPTH)
   ) u_flit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rhfda_mod_unit #(
      .DIV_W (CW)
   ) u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rhfda_pkg::lfsr_step(lfsr_ff)),
      .divisor   (nheads),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rhfda_pkg::RSP_TDATA_W - rhfda_pkg::RSP_ITEM_W)'(0), rsp_ff};

   lfsr_never_zero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("selection LFSR reached zero");

   fill_within_depth: assert property (@(posedge clock) disable iff (reset)
      !overfill)
      else $error("FIFO fill count above depth");

   delivered_flit_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.out_valid |-> rsp_ff.status == rhfda_pkg::ST_DONE)
      else $error("delivered flit with a failure status");

   remainder_unit_only_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_status.busy |-> state_ff == S_MOD)
      else $error("remainder unit busy outside the pick state");

   read_from_occupied_fifo: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> fill_ff[sel_ff] != '0)
      else $error("flit read from an empty FIFO");

endmodule

// ===== sv/rhfda_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module rhfda_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rhfda_mod_unit.sv =====
// Restoring remainder unit: LFSR value modulo a small count, one bit a cycle.
// Depends on rhfda_pkg.
module rhfda_mod_unit #(
   parameter int DIV_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rhfda_pkg::LFSR_W-1:0] dividend,
   input  logic [DIV_W-1:0]             divisor,
   output rhfda_pkg::mod_status_type    status,
   output logic [DIV_W-1:0]             remainder
);

   localparam int CNT_W = $clog2(rhfda_pkg::LFSR_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [rhfda_pkg::LFSR_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]             rem_ff, rem_in;
   logic [DIV_W-1:0]             div_ff, div_in;
   logic [DIV_W:0]               trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, dvd_ff[rhfda_pkg::LFSR_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // bring down one dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = DIV_W'(trial);
         end
         dvd_in   = dvd_ff << 1;
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(rhfda_pkg::LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   busy_and_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("remainder unit reports done while still busy");

   remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff)
      else $error("remainder not below divisor");

   done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

endmodule

// ===== bench/rx_hub_flit_delivery_arbiter_tb.sv =====
// Self-checking bench for rx_hub_flit_delivery_arbiter: directed and random push/pop
// beats, an independent arbitration predictor and an in-order response scoreboard.
// Depends on rhfda_pkg and the arbiter RTL only.
module rx_hub_flit_delivery_arbiter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF       = 5;
   localparam int MAX_GAP        = 18;       // longest idle drawn per beat, either side
   localparam int SETTLE_CYCLES  = 40;       // covers the head pick plus refresh
   localparam int PRESSURE_HOLD  = 250;      // long receiver hold-off for the back-pressure test
   localparam int CYCLE_LIMIT    = 200000;
   localparam int NSRC           = rhfda_pkg::DEF_NUM_SOURCES;
   localparam int NDEPTH         = rhfda_pkg::DEF_FIFO_DEPTH;

   localparam logic [rhfda_pkg::LFSR_W-1:0] PICK_TAPS = 16'hB400;

   // command codes
   localparam logic CMD_PUSH = rhfda_pkg::FUNC_PUSH;
   localparam logic CMD_POP  = rhfda_pkg::FUNC_POP;

   // flit kinds
   localparam logic [1:0] FLIT_HEAD  = rhfda_pkg::KIND_HEAD;
   localparam logic [1:0] FLIT_BODY  = 2'd1;
   localparam logic [1:0] FLIT_TAIL  = 2'd2;
   localparam logic [1:0] FLIT_SPARE = 2'd3;   // unused encoding, still carried through

   // register indexes
   localparam logic [rhfda_pkg::CSR_INDEX_W-1:0] REG_LIMIT  = rhfda_pkg::CSR_BUFFER_LIMIT;
   localparam logic [rhfda_pkg::CSR_INDEX_W-1:0] REG_ENABLE = rhfda_pkg::CSR_SOURCE_ENABLE;
   localparam logic [rhfda_pkg::CSR_INDEX_W-1:0] REG_SEED   = rhfda_pkg::CSR_RANDOM_SEED;
   // register index that maps to nothing
   localparam logic [rhfda_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // ---------------------------------------------------------------------------------
   // DUT connections; every input holds a known value from time zero
   // ---------------------------------------------------------------------------------
   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              csr_we     = 1'b0;
   logic [rhfda_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [rhfda_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // tdata from bit 0: source_hub, request_router, flit_dest, flit_kind, flit_payload
   logic [rhfda_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   // tuser: func (0 push, 1 pop)
   logic [0:0]                        req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // tdata from bit 0: status, out_valid, out_source, out_dest, out_kind, out_payload
   logic [rhfda_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   rx_hub_flit_delivery_arbiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Arbiter predictor state: a private copy of the registers, the per-source FIFOs and
   // the selection LFSR, advanced once per accepted command beat; the LFSR itself steps
   // only when a pop picks among waiting heads
   logic [3:0]                   buffer_cap;
   logic [7:0]                   source_mask;
   logic [rhfda_pkg::LFSR_W-1:0] pick_lfsr;
   rhfda_pkg::flit_word_type     fifo_slot [NSRC][NDEPTH];
   int unsigned                  fifo_rd   [NSRC];
   int unsigned                  fifo_wr   [NSRC];
   int unsigned                  fifo_fill [NSRC];

   // responses still owed by the DUT, oldest first
   rhfda_pkg::rsp_item_type awaited_outcomes [$];

   // traffic shaping: open packet per source and the routers a phase aims at
   int unsigned packet_left [NSRC];
   logic [5:0]  packet_dest [NSRC];
   logic [5:0]  hot_routers [3];

   bit          no_idle          = 1'b0;   // both sides run flat out while set
   int unsigned long_hold_cycles = 0;      // picked up once by the response sink
   int unsigned mismatch_count   = 0;
   int unsigned cycle_count      = 0;

   // coverage tally for the closing summary
   int unsigned stored_flits, refused_full, refused_disabled;
   int unsigned delivered_flits, lottery_picks, empty_pops;

   // Pop the head of one source FIFO and turn it into a delivery beat.
   function automatic rhfda_pkg::rsp_item_type take_flit(input int unsigned src);
      rhfda_pkg::rsp_item_type  r;
      rhfda_pkg::flit_word_type f;
      f = fifo_slot[src][fifo_rd[src]];
      r = '0;
      r.status      = rhfda_pkg::ST_DONE;
      r.out_valid   = 1'b1;
      r.out_source  = src[2:0];
      r.out_dest    = f.dest;
      r.out_kind    = f.kind;
      r.out_payload = f.payload;
      fifo_rd[src]  = (fifo_rd[src] + 1) % NDEPTH;
      fifo_fill[src]--;
      delivered_flits++;
      return r;
   endfunction

   // Work out the response to one accepted command and advance the FIFO state.
   function automatic rhfda_pkg::rsp_item_type arbitrate_beat(
      input logic func, input rhfda_pkg::req_item_type cmd);
      rhfda_pkg::rsp_item_type  r;
      rhfda_pkg::flit_word_type head;
      int unsigned  lim;
      int unsigned  src;
      int unsigned  waiting [NSRC];
      int unsigned  n_waiting;
      int unsigned  served;
      bit           found;
      r = '0;
      // clamp the limit into 1..depth: zero behaves as one
      lim = (buffer_cap == 0) ? 1 :
            ((buffer_cap > NDEPTH) ? NDEPTH : 32'(buffer_cap));
      src = 32'(cmd.source_hub);
      if (func == CMD_PUSH) begin
         if (!source_mask[src]) begin
            r.status = rhfda_pkg::ST_DISABLED;
            refused_disabled++;
         end else if (fifo_fill[src] >= lim) begin
            r.status = rhfda_pkg::ST_FULL;
            refused_full++;
         end else begin
            fifo_slot[src][fifo_wr[src]] = '{payload: cmd.flit_payload,
                                             kind: cmd.flit_kind,
                                             dest: cmd.flit_dest};
            fifo_wr[src] = (fifo_wr[src] + 1) % NDEPTH;
            fifo_fill[src]++;
            stored_flits++;
         end
         return r;
      end
      // pop: a body or tail flit (any non-head kind) on the lowest source wins outright;
      // otherwise list the waiting heads for the router in source order
      found     = 1'b0;
      n_waiting = 0;
      served    = 0;
      for (int s = 0; s < NSRC; s++) begin
         if (!found && source_mask[s] && fifo_fill[s] != 0) begin
            head = fifo_slot[s][fifo_rd[s]];
            if (head.dest == cmd.request_router) begin
               if (head.kind != FLIT_HEAD) begin
                  found  = 1'b1;
                  served = s;
               end else begin
                  waiting[n_waiting] = s;
                  n_waiting++;
               end
            end
         end
      end
      if (!found) begin
         if (n_waiting == 0) begin
            // nothing for this router: the LFSR keeps its value
            r.status = rhfda_pkg::ST_EMPTY;
            empty_pops++;
            return r;
         end
         // advance the Galois LFSR first, then take it modulo the head count
         pick_lfsr = pick_lfsr[0] ? ((pick_lfsr >> 1) ^ PICK_TAPS) : (pick_lfsr >> 1);
         served    = waiting[pick_lfsr % n_waiting];
         lottery_picks++;
      end
      return take_flit(served);
   endfunction

   function automatic rhfda_pkg::req_item_type make_beat(
      input logic [2:0] src, input logic [5:0] router, input logic [5:0] dest,
      input logic [1:0] kind, input logic [31:0] payload);
      rhfda_pkg::req_item_type c;
      c.source_hub     = src;
      c.request_router = router;
      c.flit_dest      = dest;
      c.flit_kind      = kind;
      c.flit_payload   = payload;
      return c;
   endfunction

   function automatic void compare_field(input string label, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Command side: one beat at a time, with a random idle gap in front of it
   // ---------------------------------------------------------------------------------
   // Returns at the accepting edge with tvalid still high, so a back-to-back beat can
   // replace the data without dropping valid. Anything that passes time afterwards must
   // go through settle_block, which drops valid first.
   task automatic send_beat(input logic func, input rhfda_pkg::req_item_type cmd);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rhfda_pkg::REQ_TDATA_W - rhfda_pkg::REQ_ITEM_W){1'b0}}, cmd};
      req_tuser  <= func;
      do @(posedge clock); while (req_tready !== 1'b1);
      // the DUT handles commands strictly in order, so predict at acceptance
      awaited_outcomes.insert(awaited_outcomes.size(), arbitrate_beat(func, cmd));
   endtask

   // Drop valid, wait for every owed response, then let the head refresh finish.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only ever issued with the block idle; mirror it in the predictor.
   task automatic write_csr(input logic [rhfda_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rhfda_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_LIMIT:  buffer_cap  = value[3:0];
         REG_ENABLE: source_mask = value[7:0];
         REG_SEED:   pick_lfsr   = (value == 0) ? 16'd1 : value;
         default: ;   // unknown index: ignore
      endcase
   endtask

   // Mostly enabled sources, so pushes get past the enable check.
   function automatic int unsigned pick_source();
      int unsigned s;
      s = $urandom_range(0, NSRC - 1);
      if (source_mask != 0 && $urandom_range(0, 9) != 0)
         while (!source_mask[s]) s = $urandom_range(0, NSRC - 1);
      return s;
   endfunction

   // Random traffic: well-formed packets (head, bodies, tail) towards a few hot routers,
   // pops for those routers, and a share of fully random beats as noise.
   task automatic random_traffic(input int unsigned count);
      rhfda_pkg::req_item_type cmd;
      logic [63:0]  noise;
      logic         func;
      int unsigned  roll;
      int unsigned  src;
      repeat (count) begin
         noise = {$urandom, $urandom};
         cmd   = noise[rhfda_pkg::REQ_ITEM_W-1:0];
         func  = noise[63];
         roll  = $urandom_range(0, 99);
         if (roll >= 8 && roll < 55) begin
            func = CMD_PUSH;
            src  = pick_source();
            cmd.source_hub = src[2:0];
            if (packet_left[src] == 0) begin
               packet_dest[src] = hot_routers[$urandom_range(0, 2)];
               packet_left[src] = $urandom_range(1, 4);
               cmd.flit_kind    = FLIT_HEAD;
            end else begin
               packet_left[src]--;
               cmd.flit_kind = (packet_left[src] == 0) ? FLIT_TAIL : FLIT_BODY;
            end
            cmd.flit_dest = packet_dest[src];
         end else if (roll >= 55) begin
            func = CMD_POP;
            cmd.request_router = hot_routers[$urandom_range(0, 2)];
         end
         send_beat(func, cmd);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------
   // Out of reset no source is enabled and every FIFO is empty.
   task automatic test_reset_state();
      send_beat(CMD_PUSH, make_beat(3'd3, 6'd0, 6'd5, FLIT_HEAD, 32'h1234_5678));
      send_beat(CMD_POP,  make_beat(3'd0, 6'd5, 6'd0, FLIT_HEAD, 32'h0));
   endtask

   // Limit written as zero acts as one; spare kind is served as a non-head flit;
   // a pop with nothing waiting leaves the LFSR alone; zero seed loads as one.
   task automatic test_limit_and_kinds();
      settle_block();
      write_csr(REG_ENABLE, 16'hA5FF);
      write_csr(REG_LIMIT,  16'hFFF0);
      write_csr(REG_SEED,   16'h0000);
      send_beat(CMD_PUSH, make_beat(3'd0, 6'd0,  6'd63, FLIT_HEAD,  32'h0000_0000));
      send_beat(CMD_PUSH, make_beat(3'd0, 6'd63, 6'd63, FLIT_BODY,  32'h0000_0001));
      send_beat(CMD_PUSH, make_beat(3'd7, 6'd63, 6'd0,  FLIT_SPARE, 32'hFFFF_FFFF));
      send_beat(CMD_POP,  make_beat(3'd7, 6'd0,  6'd63, FLIT_SPARE, 32'hFFFF_FFFF));
      send_beat(CMD_POP,  make_beat(3'd0, 6'd63, 6'd0,  FLIT_HEAD,  32'h0));
      send_beat(CMD_POP,  make_beat(3'd0, 6'd63, 6'd0,  FLIT_HEAD,  32'h0));
   endtask

   // Body and tail flits beat waiting heads, lowest source first; then the LFSR
   // chooses among heads, even when only one remains.
   task automatic test_wormhole_priority();
      settle_block();
      write_csr(REG_LIMIT, 16'h000F);
      write_csr(REG_SEED,  16'hFFFF);
      send_beat(CMD_PUSH, make_beat(3'd1, 6'd0, 6'd9, FLIT_HEAD, 32'hA000_0001));
      send_beat(CMD_PUSH, make_beat(3'd2, 6'd0, 6'd9, FLIT_HEAD, 32'hA000_0002));
      send_beat(CMD_PUSH, make_beat(3'd5, 6'd0, 6'd9, FLIT_TAIL, 32'hA000_0005));
      send_beat(CMD_PUSH, make_beat(3'd4, 6'd0, 6'd9, FLIT_BODY, 32'hA000_0004));
      repeat (4) send_beat(CMD_POP, make_beat(3'd0, 6'd9, 6'd0, FLIT_HEAD, 32'h0));
   endtask

   // Disabled sources are skipped but keep their flits; a lowered limit refuses
   // pushes while the held flits still drain; the unused register index is ignored.
   task automatic test_disabled_source();
      send_beat(CMD_PUSH, make_beat(3'd3, 6'd0, 6'd20, FLIT_HEAD, 32'hC000_0000));
      send_beat(CMD_PUSH, make_beat(3'd3, 6'd0, 6'd20, FLIT_HEAD, 32'hC000_0001));
      send_beat(CMD_PUSH, make_beat(3'd3, 6'd0, 6'd20, FLIT_HEAD, 32'hC000_0002));
      settle_block();
      write_csr(REG_ENABLE,       16'h00F7);
      write_csr(CSR_UNUSED_INDEX, 16'hFFFF);
      send_beat(CMD_POP,  make_beat(3'd3, 6'd20, 6'd0,  FLIT_HEAD, 32'h0));
      send_beat(CMD_PUSH, make_beat(3'd3, 6'd0,  6'd20, FLIT_HEAD, 32'hC000_0003));
      settle_block();
      write_csr(REG_ENABLE, 16'h00FF);
      write_csr(REG_LIMIT,  16'h0001);
      send_beat(CMD_PUSH, make_beat(3'd3, 6'd0, 6'd20, FLIT_HEAD, 32'hC000_0004));
      repeat (3) send_beat(CMD_POP, make_beat(3'd0, 6'd20, 6'd0, FLIT_HEAD, 32'h0));
   endtask

   // One random phase under a fresh register setting and a fresh set of hot routers.
   task automatic test_random_phase(input int unsigned count, input logic [15:0] limit_word,
                                    input logic [15:0] mask_word, input logic [15:0] seed_word,
                                    input bit flat_out);
      settle_block();
      write_csr(REG_LIMIT,  limit_word);
      write_csr(REG_ENABLE, mask_word);
      write_csr(REG_SEED,   seed_word);
      foreach (hot_routers[i])
         hot_routers[i] = 6'($urandom_range(0, rhfda_pkg::NUM_ROUTERS - 1));
      no_idle = flat_out;
      random_traffic(count);
      no_idle = 1'b0;
   endtask

   // Hold the response side off for a long stretch while commands keep coming, so the
   // output register and the holding register fill and req_tready drops.
   task automatic test_backpressure();
      settle_block();
      write_csr(REG_LIMIT,  16'h0004);
      write_csr(REG_ENABLE, 16'h00FF);
      write_csr(REG_SEED,   16'($urandom_range(1, 16'hFFFF)));
      foreach (hot_routers[i])
         hot_routers[i] = 6'($urandom_range(0, rhfda_pkg::NUM_ROUTERS - 1));
      no_idle          = 1'b1;
      long_hold_cycles = PRESSURE_HOLD;
      random_traffic(40);
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Response side: draw a stall per beat, or take the long hold when one is asked for
   // ---------------------------------------------------------------------------------
   initial begin : response_sink
      int unsigned stall;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (long_hold_cycles != 0) begin
            stall            = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // Compare every accepted response beat with the oldest prediction.
   always @(posedge clock) begin : outcome_check
      rhfda_pkg::rsp_item_type seen;
      rhfda_pkg::rsp_item_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         seen = rsp_tdata[rhfda_pkg::RSP_ITEM_W-1:0];
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: response beat with nothing awaited, expected none, actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            compare_field("status",      32'(want.status),      32'(seen.status));
            compare_field("out_valid",   32'(want.out_valid),   32'(seen.out_valid));
            compare_field("out_source",  32'(want.out_source),  32'(seen.out_source));
            compare_field("out_dest",    32'(want.out_dest),    32'(seen.out_dest));
            compare_field("out_kind",    32'(want.out_kind),    32'(seen.out_kind));
            compare_field("out_payload", want.out_payload,      seen.out_payload);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run stalled, %0d responses still owed", $time,
                  awaited_outcomes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      // predictor starts from the reset register values with empty FIFOs
      buffer_cap  = rhfda_pkg::LIMIT_RESET;
      source_mask = '0;
      pick_lfsr   = rhfda_pkg::SEED_RESET;
      foreach (fifo_fill[s]) begin
         fifo_rd[s]     = 0;
         fifo_wr[s]     = 0;
         fifo_fill[s]   = 0;
         packet_left[s] = 0;
         packet_dest[s] = '0;
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_limit_and_kinds();
      test_wormhole_priority();
      test_disabled_source();
      test_random_phase(110, 16'h0008, 16'h00FF, 16'($urandom_range(1, 16'hFFFE)), 1'b0);
      test_random_phase(100, 16'h0001, 16'($urandom_range(1, 254)), 16'hFFFF, 1'b1);
      test_backpressure();
      test_random_phase(110, 16'hABCF, 16'h00FF, 16'h8000, 1'b0);
      test_random_phase(70,  16'h0003, 16'h0081, 16'h0001, 1'b0);
      settle_block();

      $display("Run covered %0d stored flits, %0d pushes refused as full, %0d as disabled.",
               stored_flits, refused_full, refused_disabled);
      $display("Delivered %0d flits, %0d of them by LFSR pick among heads; %0d pops found none.",
               delivered_flits, lottery_picks, empty_pops);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
